// ===== hdl/rgbf_pkg.sv =====
`default_nettype none
package rgbf_pkg;

  localparam int MAX_STEPS     = 6;
  localparam int NUM_STEPS_DEF = 6;
  localparam logic [7:0] PWM_END = 8'd255;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_FRAMES_PER_STEP = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW      = 3'd7;

  typedef logic [23:0] color_t;
  typedef logic [7:0]  level_t;
  typedef logic [2:0]  step_t;

  localparam color_t STEP_RESET [MAX_STEPS] = '{
    24'h00F000, 24'h00F0F0, 24'h0000F0, 24'hF000F0, 24'hF00000, 24'hF0F000
  };
  localparam logic [7:0] FRAMES_RESET     = 8'd8;
  localparam logic       ACTIVE_LOW_RESET = 1'b1;

  typedef struct packed {
    logic [7:0] frames_per_step;
    logic       active_low;
  } ctl_t;

  typedef struct packed {
    logic  red_pin;
    logic  green_pin;
    logic  blue_pin;
    step_t step_now;
  } res_t;

endpackage
`default_nettype wire

// ===== hdl/rgbf_cfg.sv =====
`default_nettype none
module rgbf_cfg
  import rgbf_pkg::*;
#(
  parameter int NUM_STEPS = NUM_STEPS_DEF,
  localparam int IDX_W = (NUM_STEPS > 1) ? $clog2(NUM_STEPS) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [IDX_W-1:0]      sel,
  output color_t                     color,
  output ctl_t                       ctl
);

  color_t colors [NUM_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_STEPS; i++) begin
        colors[i] <= STEP_RESET[i];
      end
      ctl.frames_per_step <= FRAMES_RESET;
      ctl.active_low      <= ACTIVE_LOW_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_FRAMES_PER_STEP) begin
        ctl.frames_per_step <= cfg_data[7:0];
      end else if (cfg_index == REG_ACTIVE_LOW) begin
        ctl.active_low <= cfg_data[0];
      end else if (cfg_index < CFG_IDX_W'(NUM_STEPS)) begin
        colors[cfg_index[IDX_W-1:0]] <= cfg_data;
      end
    end
  end

  assign color = colors[sel];

endmodule
`default_nettype wire

// ===== hdl/rgbf_engine.sv =====
`default_nettype none
module rgbf_engine
  import rgbf_pkg::*;
#(
  parameter int NUM_STEPS = NUM_STEPS_DEF,
  localparam int IDX_W = (NUM_STEPS > 1) ? $clog2(NUM_STEPS) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             go,
  input  wire logic             tick,
  input  wire color_t           color,
  input  wire ctl_t             ctl,
  output logic [IDX_W-1:0]      sel,
  output res_t                  res
);

  step_t      step_index;
  level_t     red_level, green_level, blue_level;
  logic [7:0] pwm_count, frame_count;

  step_t      step_next, idx, idx_inc;
  level_t     red_next, green_next, blue_next;
  level_t     tr, tg, tb;
  logic [7:0] pwm_inc, frame_inc, pwm_next, frame_next;
  logic       adj;

  function automatic level_t move_toward(level_t lvl, level_t tgt);
    if (lvl < tgt) return lvl + 8'd1;
    if (lvl > tgt) return lvl - 8'd1;
    return lvl;
  endfunction

  assign idx = (step_index < 3'(NUM_STEPS)) ? step_index : '0;
  assign sel = idx[IDX_W-1:0];

  always_comb begin
    tr      = color[23:16];
    tg      = color[15:8];
    tb      = color[7:0];
    adj     = tick && (pwm_count == 8'd1) && (frame_count == 8'd0);
    idx_inc = idx + 3'd1;

    red_next   = red_level;
    green_next = green_level;
    blue_next  = blue_level;
    step_next  = step_index;
    if (adj) begin
      red_next   = move_toward(red_level, tr);
      green_next = move_toward(green_level, tg);
      blue_next  = move_toward(blue_level, tb);
      step_next  = idx;
      if (red_next == tr && green_next == tg && blue_next == tb) begin
        step_next = (idx_inc >= 3'(NUM_STEPS)) ? '0 : idx_inc;
      end
    end

    res.red_pin   = (pwm_count < red_next) ^ ctl.active_low;
    res.green_pin = (pwm_count < green_next) ^ ctl.active_low;
    res.blue_pin  = (pwm_count < blue_next) ^ ctl.active_low;
    res.step_now  = step_next;

    pwm_inc    = pwm_count + 8'd1;
    frame_inc  = frame_count + 8'd1;
    pwm_next   = pwm_count;
    frame_next = frame_count;
    if (tick) begin
      if (pwm_inc == PWM_END) begin
        pwm_next   = 8'd1;
        frame_next = (frame_inc == ctl.frames_per_step) ? 8'd0 : frame_inc;
      end else begin
        pwm_next = pwm_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_index  <= '0;
      red_level   <= '0;
      green_level <= '0;
      blue_level  <= '0;
      pwm_count   <= 8'd1;
      frame_count <= '0;
    end else if (go) begin
      step_index  <= step_next;
      red_level   <= red_next;
      green_level <= green_next;
      blue_level  <= blue_next;
      pwm_count   <= pwm_next;
      frame_count <= frame_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/rgb_color_cycle_fader_pwm_core.sv =====
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  tick
// out      output     out_valid / out_stall red_pin, green_pin, blue_pin, step_now
// cfg      input      cfg_we               cfg_index, cfg_data
//
// One request per clock unless in_stall; input register, then result register.
// The fader state updates as a request moves from the input to the result register.
// in_stall rises only while both registers hold data and out_stall is high.
// rst is synchronous: levels 0, step 0, PWM count 1, registers to their defaults.
`default_nettype none
module rgb_color_cycle_fader_pwm_core
  import rgbf_pkg::*;
#(
  parameter int NUM_STEPS = NUM_STEPS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  tick,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       red_pin,
  output logic                       green_pin,
  output logic                       blue_pin,
  output logic [2:0]                 step_now,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = (NUM_STEPS > 1) ? $clog2(NUM_STEPS) : 1;

  logic             s1_valid, s1_tick;
  logic             out_ready, fire;
  logic [IDX_W-1:0] sel;
  color_t           color;
  ctl_t             ctl;
  res_t             res;

  assign out_ready = !out_valid || !out_stall;
  assign fire      = s1_valid && out_ready;
  assign in_stall  = s1_valid && !out_ready;

  rgbf_cfg #(.NUM_STEPS(NUM_STEPS)) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .sel      (sel),
    .color    (color),
    .ctl      (ctl)
  );

  rgbf_engine #(.NUM_STEPS(NUM_STEPS)) u_engine (
    .clk  (clk),
    .rst  (rst),
    .go   (fire),
    .tick (s1_tick),
    .color(color),
    .ctl  (ctl),
    .sel  (sel),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_tick <= tick;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      red_pin   <= res.red_pin;
      green_pin <= res.green_pin;
      blue_pin  <= res.blue_pin;
      step_now  <= res.step_now;
    end
  end

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (step_now < 3'(NUM_STEPS)))
    else $error("step_now out of range");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled with room downstream");

  a_fire_lands: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !in_stall) |=> out_valid)
    else $error("request lost between stages");

endmodule
`default_nettype wire
